// ----- sv/cooperative_task_scheduler_top_defines.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef COOPERATIVE_TASK_SCHEDULER_TOP_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the cooperative task scheduler.
package cts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_MS_DEF   = 10;
    localparam int RESULT_LIMIT  = 16;

    localparam int MS_W     = 24;
    localparam int HANDLE_W = 16;
    localparam int RUN_W    = 8;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_ADD,
        KIND_DELETE,
        KIND_DISPATCH
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_TICK_END,
        ST_ADD_WR,
        ST_DSP_RD,
        ST_DSP_EV,
        ST_DSP_END
    } state_t;

    // One task table entry as stored in the slot memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     delay;
        logic [MS_W-1:0]     period;
        logic [RUN_W-1:0]    run;
    } slot_entry_t;

endpackage

// ----- sv/cooperative_task_scheduler_top.sv -----
`timescale 1ns / 1ps
// Top level of the time-triggered cooperative task scheduler.
//
// Input channel (s_): one transfer carries one command, its kind in s_tuser. A tick
// counts down every occupied slot, an add places a task in the first free slot, a
// delete frees a slot and a dispatch releases every ready slot once, in slot order.
// Result channel (m_): an add returns one transfer with the slot or the full flag; a
// dispatch returns one transfer per released task (at most 16), the final one with
// m_tlast, or a single none-ready transfer. Ticks and deletes return nothing.
// The task table lives in one synchronous memory with a registered read port.
// Sequencing: a delete is done in its accept cycle; a tick sweeps the table pipelined,
// reading one slot and writing back the previous one each cycle; an add first
// registers the reciprocal multiply, then writes its slot; a dispatch visits each
// slot with a memory read, then an evaluate and write-back step, and ends with a
// final result step after the last slot or once the result limit is reached.
// s_tready is high whenever no command is in progress; a finished result waits in
// the output register while the next command is already taken. A stalled receiver
// holds an add or a dispatch at its next result transfer until the register frees.
// Reset empties the table at once through per-slot occupied flags; no clearing pass.
`include "cooperative_task_scheduler_top_defines.svh"

module cooperative_task_scheduler_top #(
    parameter int MaxTasks = cts_pkg::MAX_TASKS_DEF,
    parameter int TickMs   = cts_pkg::TICK_MS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // handle [15:0], delay_ms [39:16], period_ms [63:40], slot [67:64], zero pad
    input  logic [cts_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot_index [3:0], task_handle [19:4], zero pad
    output logic [cts_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // table_full [0], none_ready [1]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    localparam int                IdxW    = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
    localparam logic [IdxW-1:0]   LastIdx = IdxW'(MaxTasks - 1);
    localparam int                CntW    = cts_pkg::CNT_W;
    localparam int                HW      = cts_pkg::HANDLE_W;
    localparam int                SW      = cts_pkg::SLOT_W;
    localparam int                MW      = cts_pkg::MS_W;

    // Input field split.
    cts_pkg::kind_t   in_kind;
    logic [HW-1:0]    in_handle;
    logic [MW-1:0]    in_delay;
    logic [MW-1:0]    in_period;
    logic [SW-1:0]    in_slot;

    assign in_kind   = cts_pkg::kind_t'(s_tuser);
    assign in_handle = s_tdata[15:0];
    assign in_delay  = s_tdata[39:16];
    assign in_period = s_tdata[63:40];
    assign in_slot   = s_tdata[67:64];

    // Control state.
    cts_pkg::state_t     state_reg, state_next;
    logic [IdxW-1:0]     idx_reg, idx_next;
    logic [MaxTasks-1:0] occ_reg, occ_next;
    logic                tick_wb_valid_reg, tick_wb_valid_next;
    logic [IdxW-1:0]     tick_wb_idx_reg, tick_wb_idx_next;
    logic [CntW-1:0]     disp_cnt_reg, disp_cnt_next;
    logic                hold_valid_reg, hold_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [IdxW-1:0]     add_slot_reg, add_slot_next;
    logic                add_full_reg, add_full_next;
    logic [HW-1:0]       add_handle_reg, add_handle_next;
    logic [SW-1:0]       hold_slot_reg, hold_slot_next;
    logic [HW-1:0]       hold_handle_reg, hold_handle_next;
    logic [SW-1:0]       m_slot_reg;
    logic [HW-1:0]       m_handle_reg;
    logic                m_full_reg;
    logic                m_none_reg;
    logic                m_last_reg;

    // Slot memory.
    cts_pkg::slot_entry_t mem [MaxTasks];
    cts_pkg::slot_entry_t rd_data_reg;
    cts_pkg::slot_entry_t wr_data;
    cts_pkg::slot_entry_t tick_entry;
    logic [IdxW-1:0]      rd_addr;
    logic [IdxW-1:0]      wr_addr;
    logic                 wr_en;

    // Result push into the output register.
    logic                 out_free;
    logic                 out_push;
    logic [SW-1:0]        out_slot;
    logic [HW-1:0]        out_handle;
    logic                 out_full;
    logic                 out_none;
    logic                 out_last;

    logic                 free_found;
    logic [IdxW-1:0]      free_idx;
    logic                 slot_ready;
    logic                 div_en;
    logic [MW-1:0]        div_delay;
    logic [MW-1:0]        div_period;

    cts_tick_div #(
        .TickMs (TickMs)
    ) u_div (
        .aclk         (aclk),
        .en           (div_en),
        .delay_ms     (in_delay),
        .period_ms    (in_period),
        .delay_ticks  (div_delay),
        .period_ticks (div_period)
    );

    assign out_free   = !m_tvalid_reg || m_tready;
    assign slot_ready = occ_reg[idx_reg] && (rd_data_reg.run != '0);

    // Lowest free slot for an add.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MaxTasks - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IdxW'(i);
            end
        end
    end

    // Tick update of one entry: count down, or reload and bump the saturating run count.
    always_comb begin
        tick_entry = rd_data_reg;
        if (rd_data_reg.delay != '0) begin
            tick_entry.delay = rd_data_reg.delay - 1'b1;
        end else begin
            tick_entry.delay = rd_data_reg.period;
            if (rd_data_reg.run != cts_pkg::RUN_MAX) begin
                tick_entry.run = rd_data_reg.run + 1'b1;
            end
        end
    end

    always_comb begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        occ_next           = occ_reg;
        disp_cnt_next      = disp_cnt_reg;
        hold_valid_next    = hold_valid_reg;
        hold_slot_next     = hold_slot_reg;
        hold_handle_next   = hold_handle_reg;
        add_slot_next      = add_slot_reg;
        add_full_next      = add_full_reg;
        add_handle_next    = add_handle_reg;
        tick_wb_valid_next = (state_reg == cts_pkg::ST_TICK);
        tick_wb_idx_next   = idx_reg;
        s_tready           = 1'b0;
        div_en             = 1'b0;
        rd_addr            = idx_reg;
        wr_en              = 1'b0;
        wr_addr            = idx_reg;
        wr_data            = rd_data_reg;
        out_push           = 1'b0;
        out_slot           = '0;
        out_handle         = '0;
        out_full           = 1'b0;
        out_none           = 1'b0;
        out_last           = 1'b0;

        // Write-back stage of the tick sweep, one slot behind the read.
        if (tick_wb_valid_reg && occ_reg[tick_wb_idx_reg]) begin
            wr_en   = 1'b1;
            wr_addr = tick_wb_idx_reg;
            wr_data = tick_entry;
        end

        unique case (state_reg)
            cts_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_kind)
                        cts_pkg::KIND_TICK: begin
                            idx_next   = '0;
                            state_next = cts_pkg::ST_TICK;
                        end
                        cts_pkg::KIND_ADD: begin
                            div_en          = 1'b1;
                            add_slot_next   = free_idx;
                            add_full_next   = !free_found;
                            add_handle_next = in_handle;
                            state_next      = cts_pkg::ST_ADD_WR;
                        end
                        cts_pkg::KIND_DELETE: begin
                            // A slot number beyond the table matches no flag.
                            for (int i = 0; i < MaxTasks; i++) begin
                                if (7'(i) == {3'b000, in_slot}) begin
                                    occ_next[i] = 1'b0;
                                end
                            end
                        end
                        cts_pkg::KIND_DISPATCH: begin
                            idx_next        = '0;
                            disp_cnt_next   = '0;
                            hold_valid_next = 1'b0;
                            state_next      = cts_pkg::ST_DSP_RD;
                        end
                    endcase
                end
            end
            cts_pkg::ST_TICK: begin
                if (idx_reg == LastIdx) begin
                    state_next = cts_pkg::ST_TICK_END;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            cts_pkg::ST_TICK_END: begin
                state_next = cts_pkg::ST_IDLE;
            end
            cts_pkg::ST_ADD_WR: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_last = 1'b1;
                    if (add_full_reg) begin
                        out_full = 1'b1;
                    end else begin
                        out_slot       = SW'(add_slot_reg);
                        wr_en          = 1'b1;
                        wr_addr        = add_slot_reg;
                        wr_data.handle = add_handle_reg;
                        wr_data.delay  = div_delay;
                        wr_data.period = div_period;
                        wr_data.run    = '0;
                        occ_next[add_slot_reg] = 1'b1;
                    end
                    state_next = cts_pkg::ST_IDLE;
                end
            end
            cts_pkg::ST_DSP_RD: begin
                state_next = cts_pkg::ST_DSP_EV;
            end
            cts_pkg::ST_DSP_EV: begin
                // The newest release waits in the hold register until the next one
                // shows up or the sweep ends, so that the final transfer gets tlast.
                if (!(slot_ready && hold_valid_reg && !out_free)) begin
                    if (slot_ready) begin
                        if (hold_valid_reg) begin
                            out_push   = 1'b1;
                            out_slot   = hold_slot_reg;
                            out_handle = hold_handle_reg;
                        end
                        hold_valid_next  = 1'b1;
                        hold_slot_next   = SW'(idx_reg);
                        hold_handle_next = rd_data_reg.handle;
                        if (rd_data_reg.period == '0) begin
                            occ_next[idx_reg] = 1'b0;
                        end else begin
                            wr_en       = 1'b1;
                            wr_addr     = idx_reg;
                            wr_data.run = rd_data_reg.run - 1'b1;
                        end
                        disp_cnt_next = disp_cnt_reg + 1'b1;
                    end
                    if (idx_reg == LastIdx || disp_cnt_next == CntW'(cts_pkg::RESULT_LIMIT)) begin
                        state_next = cts_pkg::ST_DSP_END;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = cts_pkg::ST_DSP_RD;
                    end
                end
            end
            cts_pkg::ST_DSP_END: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_last = 1'b1;
                    if (hold_valid_reg) begin
                        out_slot   = hold_slot_reg;
                        out_handle = hold_handle_reg;
                    end else begin
                        out_none = 1'b1;
                    end
                    state_next = cts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= cts_pkg::ST_IDLE;
            idx_reg           <= '0;
            occ_reg           <= '0;
            tick_wb_valid_reg <= 1'b0;
            tick_wb_idx_reg   <= '0;
            disp_cnt_reg      <= '0;
            hold_valid_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            occ_reg           <= occ_next;
            tick_wb_valid_reg <= tick_wb_valid_next;
            tick_wb_idx_reg   <= tick_wb_idx_next;
            disp_cnt_reg      <= disp_cnt_next;
            hold_valid_reg    <= hold_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        add_slot_reg    <= add_slot_next;
        add_full_reg    <= add_full_next;
        add_handle_reg  <= add_handle_next;
        hold_slot_reg   <= hold_slot_next;
        hold_handle_reg <= hold_handle_next;
        if (out_push) begin
            m_slot_reg   <= out_slot;
            m_handle_reg <= out_handle;
            m_full_reg   <= out_full;
            m_none_reg   <= out_none;
            m_last_reg   <= out_last;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_handle_reg, m_slot_reg};
    assign m_tuser  = {m_none_reg, m_full_reg};
    assign m_tlast  = m_last_reg;

    // The tick write-back always trails the read by exactly one slot.
    `CTS_ASSERT_NOW(a_tick_wb_trails, aclk, aresetn,
        tick_wb_valid_reg && (state_reg == cts_pkg::ST_TICK),
        (tick_wb_idx_reg + 1'b1) == idx_reg, "tick write-back out of step with read")

    // An add never lands on an occupied slot.
    `CTS_ASSERT_NOW(a_add_free_slot, aclk, aresetn,
        (state_reg == cts_pkg::ST_ADD_WR) && !add_full_reg,
        !occ_reg[add_slot_reg], "add targets an occupied slot")

    // A completed add leaves its slot occupied.
    `CTS_ASSERT_NEXT(a_add_marks_slot, aclk, aresetn,
        (state_reg == cts_pkg::ST_ADD_WR) && !add_full_reg && out_free,
        occ_reg[$past(add_slot_reg)], "added slot not marked occupied")

    // A held release implies the dispatch has counted at least one task.
    `CTS_ASSERT_NOW(a_hold_counted, aclk, aresetn,
        hold_valid_reg, disp_cnt_reg != '0, "held release without a count")

endmodule

// ----- sv/cts_tick_div.sv -----
`timescale 1ns / 1ps
// Converts delay and period from milliseconds to ticks by reciprocal multiplication.
module cts_tick_div #(
    parameter int TickMs = cts_pkg::TICK_MS_DEF
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [cts_pkg::MS_W-1:0]  delay_ms,
    input  logic [cts_pkg::MS_W-1:0]  period_ms,
    output logic [cts_pkg::MS_W-1:0]  delay_ticks,
    output logic [cts_pkg::MS_W-1:0]  period_ticks
);

    // For x below 2**MS_W, floor(x * Magic / 2**Shift) equals floor(x / TickMs)
    // when Shift = MS_W + ceil(log2(TickMs)) and Magic = floor(2**Shift / TickMs) + 1.
    localparam int              LogD   = $clog2(TickMs);
    localparam int              Shift  = cts_pkg::MS_W + LogD;
    localparam int              MagW   = cts_pkg::MS_W + 1;
    localparam int              ProdW  = cts_pkg::MS_W + MagW;
    localparam longint unsigned MagicL = ((64'd1 << Shift) / TickMs) + 64'd1;
    localparam logic [MagW-1:0] Magic  = MagW'(MagicL);

    logic [ProdW-1:0] delay_prod_reg;
    logic [ProdW-1:0] period_prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            delay_prod_reg  <= ProdW'(delay_ms) * ProdW'(Magic);
            period_prod_reg <= ProdW'(period_ms) * ProdW'(Magic);
        end
    end

    assign delay_ticks  = cts_pkg::MS_W'(delay_prod_reg >> Shift);
    assign period_ticks = cts_pkg::MS_W'(period_prod_reg >> Shift);

endmodule

// ----- verif/tb_cooperative_task_scheduler_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the cooperative task scheduler, with its own table predictor.
module tb_cooperative_task_scheduler_top;

    localparam int SLOTS   = cts_pkg::MAX_TASKS_DEF;
    localparam int TICK_LEN = cts_pkg::TICK_MS_DEF;
    // A full dispatch sweep is the slowest command; this covers it with margin.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
    localparam int HOLD_CYCLES   = 300;

    // One result of the scheduler, in the order the block returns them.
    typedef struct {
        logic [cts_pkg::SLOT_W-1:0]   slot;
        logic [cts_pkg::HANDLE_W-1:0] handle;
        logic                         full;
        logic                         none;
        logic                         last;
    } sched_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Every input of the block starts at a known value.
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cts_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cts_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;

    // Traffic shaping: quiet phases switch off random idling on one side.
    bit   sender_quiet   = 1'b0;
    logic receiver_quiet = 1'b0;
    logic hold_receiver  = 1'b0;

    int n_errors = 0;

    // Predicted task table.
    logic [cts_pkg::HANDLE_W-1:0] tbl_handle [SLOTS];
    bit                           tbl_used   [SLOTS];
    logic [cts_pkg::MS_W-1:0]     tbl_delay  [SLOTS];
    logic [cts_pkg::MS_W-1:0]     tbl_period [SLOTS];
    logic [cts_pkg::RUN_W-1:0]    tbl_runs   [SLOTS];

    sched_result_t pending_results[$];

    cooperative_task_scheduler_top #(
        .MaxTasks(SLOTS),
        .TickMs  (TICK_LEN)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------

    function automatic void free_entry(int s);
        tbl_handle[s] = '0;
        tbl_used[s]   = 1'b0;
        tbl_delay[s]  = '0;
        tbl_period[s] = '0;
        tbl_runs[s]   = '0;
    endfunction

    // Applies one accepted command to the predicted table and queues the
    // results that the block must return for it.
    function automatic void schedule_command(cts_pkg::kind_t k,
                                             logic [cts_pkg::HANDLE_W-1:0] h,
                                             logic [cts_pkg::MS_W-1:0] d,
                                             logic [cts_pkg::MS_W-1:0] p,
                                             logic [cts_pkg::SLOT_W-1:0] sl);
        sched_result_t r;
        int            n;
        int            free_slot;
        r = '{slot: '0, handle: '0, full: 1'b0, none: 1'b0, last: 1'b1};
        case (k)
            cts_pkg::KIND_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!tbl_used[s]) continue;
                    if (tbl_delay[s] != '0) begin
                        tbl_delay[s] = tbl_delay[s] - 1'b1;
                    end else begin
                        tbl_delay[s] = tbl_period[s];
                        if (tbl_runs[s] != cts_pkg::RUN_MAX)
                            tbl_runs[s] = tbl_runs[s] + 1'b1;
                    end
                end
            end
            cts_pkg::KIND_ADD: begin
                free_slot = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (!tbl_used[s] && free_slot < 0) free_slot = s;
                if (free_slot < 0) begin
                    r.full = 1'b1;
                end else begin
                    tbl_handle[free_slot] = h;
                    tbl_used[free_slot]   = 1'b1;
                    tbl_delay[free_slot]  = cts_pkg::MS_W'(d / TICK_LEN);
                    tbl_period[free_slot] = cts_pkg::MS_W'(p / TICK_LEN);
                    tbl_runs[free_slot]   = '0;
                    r.slot = cts_pkg::SLOT_W'(free_slot);
                end
                pending_results.push_back(r);
            end
            cts_pkg::KIND_DELETE: begin
                if (sl < SLOTS) free_entry(sl);
            end
            cts_pkg::KIND_DISPATCH: begin
                n = 0;
                for (int s = 0; s < SLOTS && n < cts_pkg::RESULT_LIMIT; s++) begin
                    if (!tbl_used[s] || tbl_runs[s] == '0) continue;
                    tbl_runs[s] = tbl_runs[s] - 1'b1;
                    r.slot   = cts_pkg::SLOT_W'(s);
                    r.handle = tbl_handle[s];
                    r.last   = 1'b0;
                    pending_results.push_back(r);
                    n++;
                    // A one-shot task leaves the table after its release.
                    if (tbl_period[s] == '0) free_entry(s);
                end
                if (n == 0) begin
                    r.none = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one command and returns at the edge where it is transferred.
    // Valid is left high so that a following command can go out back to back.
    task automatic issue_cmd(cts_pkg::kind_t k, logic [cts_pkg::HANDLE_W-1:0] h,
                             logic [cts_pkg::MS_W-1:0] d, logic [cts_pkg::MS_W-1:0] p,
                             logic [cts_pkg::SLOT_W-1:0] sl);
        if (!sender_quiet) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {4'b0, sl, p, d, h};
        do @(posedge aclk); while (!s_tready);
        schedule_command(k, h, d, p, sl);
    endtask

    // Fields a command does not use still carry random bits.
    task automatic do_tick();
        issue_cmd(cts_pkg::KIND_TICK, cts_pkg::HANDLE_W'($urandom),
                  cts_pkg::MS_W'($urandom), cts_pkg::MS_W'($urandom),
                  cts_pkg::SLOT_W'($urandom));
    endtask

    task automatic do_dispatch();
        issue_cmd(cts_pkg::KIND_DISPATCH, cts_pkg::HANDLE_W'($urandom),
                  cts_pkg::MS_W'($urandom), cts_pkg::MS_W'($urandom),
                  cts_pkg::SLOT_W'($urandom));
    endtask

    task automatic do_add(logic [cts_pkg::HANDLE_W-1:0] h, logic [cts_pkg::MS_W-1:0] d,
                          logic [cts_pkg::MS_W-1:0] p);
        issue_cmd(cts_pkg::KIND_ADD, h, d, p, cts_pkg::SLOT_W'($urandom));
    endtask

    task automatic do_delete(logic [cts_pkg::SLOT_W-1:0] sl);
        issue_cmd(cts_pkg::KIND_DELETE, cts_pkg::HANDLE_W'($urandom),
                  cts_pkg::MS_W'($urandom), cts_pkg::MS_W'($urandom), sl);
    endtask

    // Stops offering, waits for every queued result, then lets a tick or a
    // delete that returns nothing run to its end.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, checked against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_side
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result slot %0d handle %0h", $time,
                         m_tdata[3:0], m_tdata[19:4]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[3:0] !== want.slot) begin
                    $display("%0t: slot_index expected %0d got %0d", $time,
                             want.slot, m_tdata[3:0]);
                    n_errors++;
                end
                if (m_tdata[19:4] !== want.handle) begin
                    $display("%0t: task_handle expected %0h got %0h", $time,
                             want.handle, m_tdata[19:4]);
                    n_errors++;
                end
                if (m_tuser[0] !== want.full) begin
                    $display("%0t: table_full expected %0b got %0b", $time,
                             want.full, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== want.none) begin
                    $display("%0t: none_ready expected %0b got %0b", $time,
                             want.none, m_tuser[1]);
                    n_errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_tlast);
                    n_errors++;
                end
            end
        end
        m_tready <= aresetn && !hold_receiver
                    && (receiver_quiet || $urandom_range(99) >= 21);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the fields, every command kind and the named corner cases.
    task automatic test_corner_commands();
        do_dispatch();                              // nothing ready
        do_add(16'h0000, 24'd0, 24'd0);             // handle zero, one-shot
        do_add(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);   // widest delay and period
        do_add(16'h1234, 24'd9, 24'd19);            // both round down
        do_add(16'h00A5, 24'd0, 24'd5);             // one-shot, will collect runs
        do_delete(4'd15);                           // free slot stays free
        do_tick();
        do_tick();
        do_tick();
        do_dispatch();      // handle zero and the one-shot leave with runs left over
        do_dispatch();
        do_tick();
        do_dispatch();
        do_delete(4'd1);
        do_add(16'h5A5A, 24'd10, 24'd30);           // takes the lowest free slot
        do_tick();
        do_tick();
        do_dispatch();
        do_delete(4'd2);
        do_delete(4'd0);
        do_dispatch();
        drain();
    endtask

    // Fills the table, overflows it once, then empties it again.
    task automatic test_full_table();
        for (int s = 0; s < SLOTS; s++) do_delete(cts_pkg::SLOT_W'(s));
        for (int s = 0; s < SLOTS; s++)
            do_add(cts_pkg::HANDLE_W'($urandom),
                   cts_pkg::MS_W'($urandom_range(24'hFFFFFF, 1000)),
                   cts_pkg::MS_W'($urandom));
        do_add(16'hBEEF, 24'd0, 24'd0);             // no room left
        do_tick();
        do_dispatch();
        for (int s = SLOTS - 1; s >= 0; s--) do_delete(cts_pkg::SLOT_W'(s));
        drain();
    endtask

    // Lets a periodic task collect a backlog of runs, then releases it one
    // dispatch at a time until nothing is left to release.
    task automatic test_run_count_backlog();
        do_add(16'hC0DE, 24'd0, 24'd10);            // one tick period: a run every 2 ticks
        repeat (24) do_tick();
        repeat (14) do_dispatch();
        do_delete(4'd0);
        drain();
    endtask

    // Mostly live schedules with short delays and periods, some wide values
    // and some stray deletes.
    task automatic test_random_traffic(int count);
        int                       pick;
        logic [cts_pkg::MS_W-1:0] d;
        logic [cts_pkg::MS_W-1:0] p;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                do_tick();
            end else if (pick < 62) begin
                d = ($urandom_range(99) < 85) ? cts_pkg::MS_W'($urandom_range(59))
                                              : cts_pkg::MS_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 30)      p = cts_pkg::MS_W'($urandom_range(9));
                else if (pick < 85) p = cts_pkg::MS_W'($urandom_range(59, 10));
                else                p = cts_pkg::MS_W'($urandom);
                do_add(cts_pkg::HANDLE_W'($urandom), d, p);
            end else if (pick < 72) begin
                do_delete(cts_pkg::SLOT_W'($urandom));
            end else begin
                do_dispatch();
            end
        end
        drain();
    endtask

    // The receiver stops for a long stretch while commands keep coming, so the
    // output register fills and the block must stall its input.
    task automatic test_backpressure();
        fork
            begin
                hold_receiver <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_receiver <= 1'b0;
            end
        join_none
        sender_quiet = 1'b1;
        for (int i = 0; i < 8; i++)
            do_add(cts_pkg::HANDLE_W'($urandom), 24'd0, cts_pkg::MS_W'($urandom_range(29)));
        repeat (3) begin
            do_tick();
            do_dispatch();
        end
        do_dispatch();
        sender_quiet = 1'b0;
        drain();
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) free_entry(s);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_commands();
        test_full_table();
        test_run_count_backlog();
        test_random_traffic(130);

        // A long stretch with both sides running flat out.
        sender_quiet = 1'b1;
        receiver_quiet <= 1'b1;
        test_random_traffic(100);
        sender_quiet = 1'b0;
        receiver_quiet <= 1'b0;

        test_backpressure();

        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: a healthy run takes well under a tenth of this.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- cooperative_task_scheduler_top.f -----
+incdir+sv
sv/cts_pkg.sv
sv/cts_tick_div.sv
sv/cooperative_task_scheduler_top.sv
verif/tb_cooperative_task_scheduler_top.sv
